>>> rtl/fraction_add_and_reduce_macros.svh
`ifndef FRACTION_ADD_AND_REDUCE_MACROS_SVH
`define FRACTION_ADD_AND_REDUCE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define FRAC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fraction unit check failed");

// next-cycle implication, sampled on clk, off during reset
`define FRAC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fraction unit check failed");

`endif

>>> rtl/frac_pkg.sv
package frac_pkg;

	localparam int FIELD_W   = 32;
	localparam int WIDE_W    = 66;
	localparam int WIDTH_DEF = 32;
	localparam int CNT_W     = $clog2(FIELD_W);

	typedef enum logic {
		OP_ADD  = 1'b0,
		OP_NORM = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_ZDEN = 2'd1,
		STAT_OVF  = 2'd2
	} status_t;

	typedef struct packed {
		logic               start;
		logic [FIELD_W-1:0] dividend;
		logic [FIELD_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [FIELD_W-1:0] quot;
		logic [FIELD_W-1:0] rem;
	} div_rsp_t;

endpackage

>>> rtl/fraction_add_and_reduce.sv
// Add: one division of |num_a| by |den_a| for the integer flag, three multiplier
// passes and one add. Normalize of an integer: that one division. Normalize with
// reduction: that division, then the binary GCD loop on one subtractor and two
// more passes of the bit-serial divider.
// One transaction at a time; a new item is taken only back in idle, and a zero
// denominator goes straight to the result. Reset: arst_n clears sequencer and valids at once.
module fraction_add_and_reduce #(
	parameter int WIDTH = frac_pkg::WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic                                opcode,
	input  logic signed [frac_pkg::FIELD_W-1:0] num_a,
	input  logic signed [frac_pkg::FIELD_W-1:0] den_a,
	input  logic signed [frac_pkg::FIELD_W-1:0] num_b,
	input  logic signed [frac_pkg::FIELD_W-1:0] den_b,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic signed [frac_pkg::FIELD_W-1:0] num_out,
	output logic signed [frac_pkg::FIELD_W-1:0] den_out,
	output logic                                a_is_integer,
	output logic [1:0]                          status
);

	localparam int FW = frac_pkg::FIELD_W;
	localparam int XW = frac_pkg::WIDE_W;
	localparam int SH = XW - WIDTH;

	localparam logic [1:0] M_NADB = 2'd0;
	localparam logic [1:0] M_NBDA = 2'd1;
	localparam logic [1:0] M_DADB = 2'd2;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_DIVA = 8'b0000_0010,
		S_MUL  = 8'b0000_0100,
		S_ADD  = 8'b0000_1000,
		S_GCD  = 8'b0001_0000,
		S_DIVN = 8'b0010_0000,
		S_DIVD = 8'b0100_0000,
		S_FIN  = 8'b1000_0000
	} state_t;

	state_t                     state_q;
	frac_pkg::div_req_t         req_q;
	frac_pkg::div_rsp_t         rsp;
	logic                       op_q;
	logic signed [FW-1:0]       na_q, da_q, nb_q, db_q;
	logic [FW-1:0]              an_q, ad_q;
	logic                       neg_q;
	logic                       err_q;
	logic                       is_int_q;
	logic [1:0]                 mcnt_q;
	logic signed [2*FW-1:0]     p2_q;
	logic signed [XW-1:0]       rn_q, rd_q;
	logic [FW-1:0]              u_q, v_q, g_q;
	logic [frac_pkg::CNT_W-1:0] k_q;
	logic                       res_valid_q;
	logic signed [FW-1:0]       num_q, den_q;
	logic                       int_q;
	logic [1:0]                 stat_q;

	logic signed [FW-1:0]       mul_x, mul_y;
	logic signed [2*FW-1:0]     prod;
	logic signed [XW-1:0]       mag_w;
	logic signed [XW-1:0]       smag_w;
	logic [FW:0]                sub_uv;
	logic [FW-1:0]              g_next;
	logic signed [XW-1:0]       ext_n, ext_d, hi_n, hi_d;
	logic                       fits_n, fits_d;

	frac_divu u_divu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_q),
		.rsp    (rsp)
	);

	always_comb begin
		case (mcnt_q)
			M_NADB: begin
				mul_x = na_q;
				mul_y = db_q;
			end
			M_NBDA: begin
				mul_x = nb_q;
				mul_y = da_q;
			end
			default: begin
				mul_x = da_q;
				mul_y = db_q;
			end
		endcase
	end

	assign prod   = mul_x * mul_y;
	assign mag_w  = $signed({{(XW-FW){1'b0}}, rsp.quot});
	assign smag_w = neg_q ? -mag_w : mag_w;
	assign sub_uv = {1'b0, u_q} - {1'b0, v_q};
	assign g_next = (u_q | v_q) << k_q;

	assign ext_n  = (rn_q <<< SH) >>> SH;
	assign ext_d  = (rd_q <<< SH) >>> SH;
	assign hi_n   = rn_q >>> (WIDTH - 1);
	assign hi_d   = rd_q >>> (WIDTH - 1);
	assign fits_n = (hi_n == '0) || (hi_n == '1);
	assign fits_d = (hi_d == '0) || (hi_d == '1);

	assign item_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			req_q.start <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			req_q.start <= 1'b0;
			if (res_valid_q && !result_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						op_q  <= opcode;
						na_q  <= num_a;
						da_q  <= den_a;
						nb_q  <= num_b;
						db_q  <= den_b;
						an_q  <= num_a[FW-1] ? FW'(-num_a) : num_a;
						ad_q  <= den_a[FW-1] ? FW'(-den_a) : den_a;
						neg_q <= num_a[FW-1] ^ den_a[FW-1];
						if (den_a == '0 ||
								(opcode == frac_pkg::OP_ADD && den_b == '0)) begin
							err_q   <= 1'b1;
							state_q <= S_FIN;
						end else begin
							err_q          <= 1'b0;
							req_q.start    <= 1'b1;
							req_q.dividend <= num_a[FW-1] ? FW'(-num_a) : num_a;
							req_q.divisor  <= den_a[FW-1] ? FW'(-den_a) : den_a;
							state_q        <= S_DIVA;
						end
					end
				end
				S_DIVA: begin
					if (rsp.done) begin
						is_int_q <= (rsp.rem == '0);
						if (op_q == frac_pkg::OP_ADD) begin
							mcnt_q  <= M_NADB;
							state_q <= S_MUL;
						end else if (rsp.rem == '0) begin
							rn_q    <= smag_w;
							rd_q    <= XW'(1);
							state_q <= S_FIN;
						end else begin
							u_q     <= an_q;
							v_q     <= ad_q;
							k_q     <= '0;
							state_q <= S_GCD;
						end
					end
				end
				S_MUL: begin
					mcnt_q <= mcnt_q + 1'b1;
					case (mcnt_q)
						M_NADB: rn_q <= XW'(prod);
						M_NBDA: p2_q <= prod;
						default: begin
							rd_q    <= XW'(prod);
							state_q <= S_ADD;
						end
					endcase
				end
				S_ADD: begin
					rn_q    <= rn_q + XW'(p2_q);
					state_q <= S_FIN;
				end
				S_GCD: begin
					if (u_q == '0 || v_q == '0) begin
						g_q            <= g_next;
						req_q.start    <= 1'b1;
						req_q.dividend <= an_q;
						req_q.divisor  <= g_next;
						state_q        <= S_DIVN;
					end else if (!u_q[0] && !v_q[0]) begin
						u_q <= u_q >> 1;
						v_q <= v_q >> 1;
						k_q <= k_q + 1'b1;
					end else if (!u_q[0]) begin
						u_q <= u_q >> 1;
					end else if (!v_q[0]) begin
						v_q <= v_q >> 1;
					end else if (!sub_uv[FW]) begin
						u_q <= sub_uv[FW-1:0];
					end else begin
						v_q <= -sub_uv[FW-1:0];
					end
				end
				S_DIVN: begin
					if (rsp.done) begin
						rn_q           <= smag_w;
						req_q.start    <= 1'b1;
						req_q.dividend <= ad_q;
						req_q.divisor  <= g_q;
						state_q        <= S_DIVD;
					end
				end
				S_DIVD: begin
					if (rsp.done) begin
						rd_q    <= mag_w;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!res_valid_q || !result_stall) begin
						res_valid_q <= 1'b1;
						if (err_q) begin
							num_q  <= '0;
							den_q  <= '0;
							int_q  <= 1'b0;
							stat_q <= frac_pkg::STAT_ZDEN;
						end else begin
							num_q  <= ext_n[FW-1:0];
							den_q  <= ext_d[FW-1:0];
							int_q  <= is_int_q;
							stat_q <= (fits_n && fits_d) ? frac_pkg::STAT_OK
								: frac_pkg::STAT_OVF;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result_valid = res_valid_q;
	assign num_out      = num_q;
	assign den_out      = den_q;
	assign a_is_integer = int_q;
	assign status       = stat_q;

endmodule

>>> rtl/frac_divu.sv
module frac_divu (
	input  logic                clk,
	input  logic                arst_n,
	input  frac_pkg::div_req_t  req,
	output frac_pkg::div_rsp_t  rsp
);

	localparam int W = frac_pkg::FIELD_W;

	logic                       busy_q;
	logic                       done_q;
	logic [frac_pkg::CNT_W-1:0] cnt_q;
	logic [W-1:0]               rem_q;
	logic [W-1:0]               quo_q;
	logic [W-1:0]               dvs_q;
	logic [W:0]                 shifted;
	logic [W:0]                 diff;
	logic                       ge;

	assign shifted = {rem_q, quo_q[W-1]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign ge      = ~diff[W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= '0;
				quo_q  <= req.dividend;
				dvs_q  <= req.divisor;
			end else if (busy_q) begin
				rem_q <= ge ? diff[W-1:0] : shifted[W-1:0];
				quo_q <= {quo_q[W-2:0], ge};
				if (cnt_q == frac_pkg::CNT_W'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
	assign rsp.rem  = rem_q;

endmodule

>>> rtl/frac_checker.sv
`include "fraction_add_and_reduce_macros.svh"

module frac_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                item_valid,
	input logic                                item_stall,
	input logic                                opcode,
	input logic signed [frac_pkg::FIELD_W-1:0] num_a,
	input logic signed [frac_pkg::FIELD_W-1:0] den_a,
	input logic signed [frac_pkg::FIELD_W-1:0] num_b,
	input logic signed [frac_pkg::FIELD_W-1:0] den_b,
	input logic                                result_valid,
	input logic                                result_stall,
	input logic signed [frac_pkg::FIELD_W-1:0] num_out,
	input logic signed [frac_pkg::FIELD_W-1:0] den_out,
	input logic                                a_is_integer,
	input logic [1:0]                          status
);

	`FRAC_ASSERT_NXT(busy_after_accept, item_valid && !item_stall, item_stall)

	`FRAC_ASSERT_IMP(result_from_busy, $rose(result_valid), $past(item_stall))

	`FRAC_ASSERT_IMP(zden_clears_fields, result_valid && status == frac_pkg::STAT_ZDEN,
		num_out == '0 && den_out == '0 && !a_is_integer)

	`FRAC_ASSERT_NXT(result_holds, result_valid && result_stall,
		result_valid && $stable(num_out) && $stable(den_out) &&
		$stable(a_is_integer) && $stable(status))

endmodule

bind fraction_add_and_reduce frac_checker u_frac_checker (.*);
